// ----- src/tcc_pkg.sv -----
// Package for the TCP connection controller: protocol codes, reset values,
// queue entry and result record types, and the sequence advance helper.
// No dependencies.
package tcc_pkg;

  // Default sizing
  localparam int unsigned QUEUE_DEPTH_DEF        = 16;
  localparam int unsigned MAX_WRITE_SEGMENTS_DEF = 64;

  // TCP flag bits
  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_RST = 8'h04;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;

  // Request actions
  localparam logic [2:0] ACT_SEGMENT   = 3'd0;
  localparam logic [2:0] ACT_ACCEPT    = 3'd1;
  localparam logic [2:0] ACT_WRITE     = 3'd2;
  localparam logic [2:0] ACT_READ_DONE = 3'd3;
  localparam logic [2:0] ACT_CLOSE     = 3'd4;
  localparam logic [2:0] ACT_TICK      = 3'd5;

  // Connection states as reported
  localparam logic [2:0] CS_CLOSED       = 3'd0;
  localparam logic [2:0] CS_WAIT_EST     = 3'd1;
  localparam logic [2:0] CS_ESTABLISHING = 3'd2;
  localparam logic [2:0] CS_ESTABLISHED  = 3'd3;
  localparam logic [2:0] CS_FIN_WAIT_1   = 3'd4;
  localparam logic [2:0] CS_FIN_WAIT_2   = 3'd5;
  localparam logic [2:0] CS_CLOSE_WAIT   = 3'd6;
  localparam logic [2:0] CS_RELEASED     = 3'd7;

  // Application event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_NEW_CONN = 3'd1;
  localparam logic [2:0] EV_CONNECT  = 3'd2;
  localparam logic [2:0] EV_RECEIVED = 3'd3;
  localparam logic [2:0] EV_WRITTEN  = 3'd4;
  localparam logic [2:0] EV_CLOSED   = 3'd5;
  localparam logic [2:0] EV_WR_ACC   = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] CFG_INIT_SEQ   = 3'd0;
  localparam logic [2:0] CFG_LOCAL_WIN  = 3'd1;
  localparam logic [2:0] CFG_LOCAL_MSS  = 3'd2;
  localparam logic [2:0] CFG_FIN_TO     = 3'd3;
  localparam logic [2:0] CFG_RTO        = 3'd4;
  localparam logic [2:0] CFG_MAX_SEND   = 3'd5;

  // Configuration reset values
  localparam logic [31:0] RST_INIT_SEQ  = 32'd0;
  localparam logic [15:0] RST_LOCAL_WIN = 16'd65535;
  localparam logic [15:0] RST_LOCAL_MSS = 16'd1460;
  localparam logic [31:0] RST_FIN_TO    = 32'd20000;
  localparam logic [31:0] RST_RTO       = 32'd2000;
  localparam logic [1:0]  RST_MAX_SEND  = 2'd2;

  // One retransmit queue descriptor
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [15:0] plen;
    logic [15:0] doff;
    logic [1:0]  cnt;
    logic [31:0] sent;
    logic [15:0] win;
  } q_entry_t;

  // One result record (connection state is added at the output)
  typedef struct packed {
    logic        send_valid;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] win;
    logic [15:0] plen;
    logic [15:0] doff;
    logic [2:0]  ev;
    logic [15:0] evlen;
    logic        last;
  } res_t;

  // Sequence space taken by a segment
  function automatic logic [31:0] adv_seq(input logic [31:0] seq, input logic [7:0] flags,
                                          input logic [15:0] len);
    logic [31:0] r;
    if (len != 16'd0) r = seq + {16'd0, len};
    else if ((flags & (FLAG_SYN | FLAG_FIN)) != 8'd0) r = seq + 32'd1;
    else r = seq;
    return r;
  endfunction

endpackage

// ----- src/tcp_connection_controller_top.sv -----
// TCP connection controller, top level: connection sequencer, result FIFO
// and retransmit queue. Depends on tcc_pkg and tcc_ram.
//
// A request is taken once every result of the previous request has been
// delivered. An arriving ACK retires queue entries one at a time, and the
// segments of a write stream out while the split is still running; other
// results leave once the request is done, at one per cycle while out_stall
// is low. All requests share the single sequencer, and the retransmit queue
// memory has registered read data.
module tcp_connection_controller_top #(
  parameter int unsigned QUEUE_DEPTH        = tcc_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_WRITE_SEGMENTS = tcc_pkg::MAX_WRITE_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_seg_flags,
  input  logic [31:0] in_seg_seq,
  input  logic [31:0] in_seg_ack,
  input  logic [15:0] in_seg_window,
  input  logic [15:0] in_length,
  input  logic        in_mss_present,
  input  logic [15:0] in_peer_mss,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_send_valid,
  output logic [7:0]  out_tx_flags,
  output logic [31:0] out_tx_seq,
  output logic [31:0] out_tx_ack,
  output logic [15:0] out_tx_window,
  output logic [15:0] out_tx_payload_len,
  output logic [15:0] out_tx_data_offset,
  output logic [2:0]  out_event_code,
  output logic [15:0] out_event_length,
  output logic [2:0]  out_conn_state,
  output logic        out_last
);

  localparam int unsigned QW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW  = QW + 2;
  localparam int unsigned SGW = $clog2(MAX_WRITE_SEGMENTS + 1);
  localparam int unsigned FD  = 8;
  localparam int unsigned FW  = $clog2(FD);
  localparam int unsigned FCW = $clog2(FD + 1);
  localparam int unsigned QEW = $bits(tcc_pkg::q_entry_t);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_DISP     = 18'h00002,
    S_SEG      = 18'h00004,
    S_SEG2     = 18'h00008,
    S_SEG3     = 18'h00010,
    S_ACK_WAIT = 18'h00020,
    S_ACK_CHK  = 18'h00040,
    S_ACK_EV1  = 18'h00080,
    S_ACK_EV2  = 18'h00100,
    S_POST     = 18'h00200,
    S_POST2    = 18'h00400,
    S_REL      = 18'h00800,
    S_RD       = 18'h01000,
    S_RD2      = 18'h02000,
    S_TICK     = 18'h04000,
    S_WCALC    = 18'h08000,
    S_WEMIT    = 18'h10000,
    S_FINISH   = 18'h20000
  } seq_t;

  // configuration registers
  logic [31:0] cfg_iss_r, cfg_fin_to_r, cfg_rto_r;
  logic [15:0] cfg_lwin_r, cfg_mss_r;
  logic [1:0]  cfg_max_send_r;

  // connection state
  seq_t        seq_r, seq_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [31:0] snd_r, snd_nxt, rcv_r, rcv_nxt, last_ack_r, last_ack_nxt;
  logic [31:0] fin_time_r, fin_time_nxt;
  logic [15:0] pw_r, pw_nxt, own_r, own_nxt, peer_mss_r, peer_mss_nxt;
  logic        push_pend_r, push_pend_nxt;
  logic [QW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // per-request working registers
  logic          write_step_r, write_step_nxt, pushed_r, pushed_nxt;
  logic          syn_f_r, syn_f_nxt, fin_f_r, fin_f_nxt, rd_flag_r, rd_flag_nxt;
  logic [16:0]   acc_r, acc_nxt;
  logic [15:0]   woff_r, woff_nxt, wl_r, wl_nxt;
  logic [SGW-1:0] wsegs_r, wsegs_nxt;

  // latched request fields
  logic [2:0]  i_action_r;
  logic [7:0]  i_flags_r;
  logic [31:0] i_seq_r, i_ack_r, i_now_r;
  logic [15:0] i_win_r, i_len_r, i_peer_mss_r;
  logic        i_mss_present_r;

  // result FIFO
  tcc_pkg::res_t fifo_mem [FD];
  logic [FW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FCW-1:0] fifo_cnt_r;
  logic           push, pop, set_last, drain_ok, in_acc;
  tcc_pkg::res_t  push_res, seg_base, out_res;

  // queue memory access
  logic              ram_we;
  logic [QW-1:0]     ram_waddr, tail;
  tcc_pkg::q_entry_t ram_wdata, q_rd;
  logic [QEW-1:0]    ram_rdata;
  logic              enq;
  logic [7:0]        enq_flags;
  logic [15:0]       enq_plen, enq_doff;
  logic              do_fresh, do_rel;

  // helpers
  logic [SW-1:0]  tail_sum;
  logic [QW-1:0]  head_inc;
  logic           q_full;
  logic [31:0]    ack_diff, tick_age;
  logic [16:0]    acc_sum, rd_sum, rd_w, off_n;
  logic [15:0]    rem, wl_a, wl_c, pw_n;
  logic           loop_ok, psh, is_last;
  logic [SGW-1:0] segs_n;

  tcc_ram #(.WIDTH(QEW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (head_r),
    .rd_data (ram_rdata)
  );
  assign q_rd = tcc_pkg::q_entry_t'(ram_rdata);

  // handshakes
  assign in_stall  = !(seq_r == S_IDLE && fifo_cnt_r == '0);
  assign in_acc    = in_valid && !in_stall;
  assign drain_ok  = (seq_r == S_IDLE) || write_step_r;
  assign out_valid = (fifo_cnt_r != '0) && drain_ok;
  assign pop       = out_valid && !out_stall;

  // queue index arithmetic
  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? QW'(tail_sum - SW'(QUEUE_DEPTH))
                                                    : QW'(tail_sum);
  assign head_inc = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign q_full   = (count_r == CW'(QUEUE_DEPTH));

  // datapath terms
  assign ack_diff = q_rd.seq - i_ack_r;
  assign tick_age = i_now_r - q_rd.sent;
  assign acc_sum  = acc_r + {1'b0, q_rd.plen};
  assign rd_sum   = {1'b0, own_r} + {1'b0, i_len_r};
  assign rd_w     = (rd_sum > {1'b0, cfg_lwin_r}) ? {1'b0, cfg_lwin_r} : rd_sum;
  assign rem      = i_len_r - woff_r;
  assign wl_a     = (peer_mss_r > rem) ? rem : peer_mss_r;
  assign wl_c     = (wl_a > pw_r) ? pw_r : wl_a;
  assign loop_ok  = (woff_r < i_len_r) && (pw_r != 16'd0)
                    && (wsegs_r < SGW'(MAX_WRITE_SEGMENTS)) && !q_full;
  assign off_n    = {1'b0, woff_r} + {1'b0, wl_r};
  assign pw_n     = pw_r - wl_r;
  assign segs_n   = wsegs_r + 1'b1;
  assign psh      = (off_n >= {1'b0, i_len_r}) || (wl_r >= pw_r);
  assign is_last  = !((off_n < {1'b0, i_len_r}) && (pw_n != 16'd0)
                      && (segs_n < SGW'(MAX_WRITE_SEGMENTS))
                      && (count_r < CW'(QUEUE_DEPTH - 1)));

  // segment template from current connection state
  always_comb begin
    seg_base            = '0;
    seg_base.send_valid = 1'b1;
    seg_base.seq        = snd_r;
    seg_base.ack        = rcv_r;
    seg_base.win        = own_r;
  end

  // sequencer
  always_comb begin
    seq_nxt        = seq_r;
    st_nxt         = st_r;
    snd_nxt        = snd_r;
    rcv_nxt        = rcv_r;
    last_ack_nxt   = last_ack_r;
    fin_time_nxt   = fin_time_r;
    pw_nxt         = pw_r;
    own_nxt        = own_r;
    peer_mss_nxt   = peer_mss_r;
    push_pend_nxt  = push_pend_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    write_step_nxt = write_step_r;
    pushed_nxt     = pushed_r;
    syn_f_nxt      = syn_f_r;
    fin_f_nxt      = fin_f_r;
    rd_flag_nxt    = rd_flag_r;
    acc_nxt        = acc_r;
    woff_nxt       = woff_r;
    wl_nxt         = wl_r;
    wsegs_nxt      = wsegs_r;
    push           = 1'b0;
    push_res       = '0;
    set_last       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = tail;
    ram_wdata      = '0;
    enq            = 1'b0;
    enq_flags      = '0;
    enq_plen       = '0;
    enq_doff       = '0;
    do_fresh       = 1'b0;
    do_rel         = 1'b0;

    unique case (seq_r)
      S_IDLE: begin
        if (in_acc) begin
          pushed_nxt     = 1'b0;
          write_step_nxt = (in_action == tcc_pkg::ACT_WRITE);
          seq_nxt        = S_DISP;
        end
      end

      S_DISP: begin
        seq_nxt = S_FINISH;
        case (i_action_r)
          tcc_pkg::ACT_SEGMENT: seq_nxt = S_SEG;
          tcc_pkg::ACT_ACCEPT: begin
            if (st_r == tcc_pkg::CS_WAIT_EST) begin
              st_nxt = tcc_pkg::CS_ESTABLISHING;
              if (i_mss_present_r) peer_mss_nxt = i_peer_mss_r;
              push           = 1'b1;
              push_res       = seg_base;
              push_res.flags = tcc_pkg::FLAG_SYN | tcc_pkg::FLAG_ACK;
              push_res.doff  = cfg_mss_r;
              last_ack_nxt   = rcv_r;
              enq            = !q_full;
              enq_flags      = tcc_pkg::FLAG_SYN | tcc_pkg::FLAG_ACK;
              enq_doff       = cfg_mss_r;
              snd_nxt        = snd_r + 32'd1;
            end
          end
          tcc_pkg::ACT_WRITE: begin
            if (st_r != tcc_pkg::CS_ESTABLISHED || push_pend_r) begin
              push          = 1'b1;
              push_res.ev   = tcc_pkg::EV_WR_ACC;
              push_res.last = 1'b1;
            end else begin
              woff_nxt  = '0;
              wsegs_nxt = '0;
              seq_nxt   = S_WCALC;
            end
          end
          tcc_pkg::ACT_READ_DONE: begin
            if (st_r == tcc_pkg::CS_ESTABLISHED) seq_nxt = S_RD;
          end
          tcc_pkg::ACT_CLOSE: begin
            if (st_r == tcc_pkg::CS_CLOSED) begin
              seq_nxt = S_REL;
            end else if (st_r == tcc_pkg::CS_WAIT_EST || st_r == tcc_pkg::CS_ESTABLISHING) begin
              push           = 1'b1;
              push_res       = seg_base;
              push_res.flags = tcc_pkg::FLAG_RST | tcc_pkg::FLAG_ACK;
              last_ack_nxt   = rcv_r;
              seq_nxt        = S_REL;
            end else if (st_r == tcc_pkg::CS_ESTABLISHED) begin
              st_nxt         = tcc_pkg::CS_FIN_WAIT_1;
              fin_time_nxt   = i_now_r;
              push           = 1'b1;
              push_res       = seg_base;
              push_res.flags = tcc_pkg::FLAG_FIN | tcc_pkg::FLAG_ACK;
              last_ack_nxt   = rcv_r;
              enq            = !q_full;
              enq_flags      = tcc_pkg::FLAG_FIN | tcc_pkg::FLAG_ACK;
              snd_nxt        = snd_r + 32'd1;
            end
          end
          tcc_pkg::ACT_TICK: begin
            if ((st_r == tcc_pkg::CS_FIN_WAIT_1 || st_r == tcc_pkg::CS_FIN_WAIT_2)
                && (i_now_r - fin_time_r) >= cfg_fin_to_r) begin
              seq_nxt = S_REL;
            end else if (count_r != '0) begin
              seq_nxt = S_TICK;
            end
          end
          default: seq_nxt = S_FINISH;
        endcase
      end

      // no connection: reset reply or fresh start on SYN
      S_SEG: begin
        seq_nxt = S_SEG2;
        if (st_r == tcc_pkg::CS_CLOSED || st_r == tcc_pkg::CS_RELEASED) begin
          if ((i_flags_r & tcc_pkg::FLAG_SYN) == 8'd0) begin
            if ((i_flags_r & tcc_pkg::FLAG_RST) == 8'd0) begin
              push                = 1'b1;
              push_res.send_valid = 1'b1;
              push_res.flags      = tcc_pkg::FLAG_RST | tcc_pkg::FLAG_ACK;
              push_res.seq        = i_ack_r;
              push_res.ack        = tcc_pkg::adv_seq(i_seq_r, i_flags_r, i_len_r);
              push_res.win        = cfg_lwin_r;
            end
            seq_nxt = S_FINISH;
          end else begin
            do_fresh = 1'b1;
          end
        end
      end

      // duplicate / out of order, else take the segment
      S_SEG2: begin
        if ((i_flags_r == tcc_pkg::FLAG_ACK && i_seq_r == rcv_r - 32'd1)
            || (rcv_r != 32'd0 && i_seq_r != rcv_r)) begin
          push           = 1'b1;
          push_res       = seg_base;
          push_res.flags = tcc_pkg::FLAG_ACK;
          last_ack_nxt   = rcv_r;
          seq_nxt        = S_FINISH;
        end else begin
          rcv_nxt = tcc_pkg::adv_seq(i_seq_r, i_flags_r, i_len_r);
          pw_nxt  = i_win_r;
          if ((i_flags_r & tcc_pkg::FLAG_PSH) != 8'd0 || i_len_r != 16'd0) begin
            own_nxt        = (own_r > i_len_r) ? own_r - i_len_r : 16'd0;
            push           = 1'b1;
            push_res.ev    = tcc_pkg::EV_RECEIVED;
            push_res.evlen = i_len_r;
          end
          seq_nxt = S_SEG3;
        end
      end

      // ACK for received data, then ACK processing
      S_SEG3: begin
        if (i_len_r != 16'd0) begin
          push           = 1'b1;
          push_res       = seg_base;
          push_res.flags = tcc_pkg::FLAG_ACK;
          last_ack_nxt   = rcv_r;
        end
        syn_f_nxt = 1'b0;
        fin_f_nxt = 1'b0;
        acc_nxt   = '0;
        seq_nxt   = ((i_flags_r & tcc_pkg::FLAG_ACK) != 8'd0) ? S_ACK_WAIT : S_POST;
      end

      S_ACK_WAIT: seq_nxt = S_ACK_CHK;

      // retire acknowledged queue head
      S_ACK_CHK: begin
        if (count_r == '0 || !ack_diff[31]) begin
          seq_nxt = S_ACK_EV1;
        end else begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
          if ((q_rd.flags & tcc_pkg::FLAG_SYN) != 8'd0) begin
            st_nxt    = tcc_pkg::CS_ESTABLISHED;
            syn_f_nxt = 1'b1;
          end
          if (q_rd.plen != 16'd0) begin
            if ((q_rd.flags & tcc_pkg::FLAG_PSH) != 8'd0) push_pend_nxt = 1'b0;
            acc_nxt = acc_sum[16] ? 17'h10000 : acc_sum;
          end
          if ((q_rd.flags & tcc_pkg::FLAG_FIN) != 8'd0) fin_f_nxt = 1'b1;
          seq_nxt = S_ACK_WAIT;
        end
      end

      S_ACK_EV1: begin
        if (syn_f_r) begin
          push        = 1'b1;
          push_res.ev = tcc_pkg::EV_CONNECT;
        end
        seq_nxt = S_ACK_EV2;
      end

      S_ACK_EV2: begin
        if (acc_r != '0) begin
          push           = 1'b1;
          push_res.ev    = tcc_pkg::EV_WRITTEN;
          push_res.evlen = acc_r[16] ? 16'hFFFF : acc_r[15:0];
        end
        seq_nxt = S_POST;
        if (fin_f_r && st_r == tcc_pkg::CS_FIN_WAIT_1) begin
          st_nxt       = tcc_pkg::CS_FIN_WAIT_2;
          fin_time_nxt = i_now_r;
        end else if (fin_f_r && st_r == tcc_pkg::CS_CLOSE_WAIT) begin
          seq_nxt = S_REL;
        end
      end

      // RST and SYN of the arriving segment
      S_POST: begin
        if ((i_flags_r & tcc_pkg::FLAG_RST) != 8'd0) begin
          seq_nxt = S_REL;
        end else begin
          if ((i_flags_r & tcc_pkg::FLAG_SYN) != 8'd0) begin
            st_nxt      = tcc_pkg::CS_WAIT_EST;
            push        = 1'b1;
            push_res.ev = tcc_pkg::EV_NEW_CONN;
          end
          seq_nxt = S_POST2;
        end
      end

      // FIN of the arriving segment
      S_POST2: begin
        seq_nxt = S_FINISH;
        if ((i_flags_r & tcc_pkg::FLAG_FIN) != 8'd0) begin
          if (st_r == tcc_pkg::CS_FIN_WAIT_2) begin
            push           = 1'b1;
            push_res       = seg_base;
            push_res.flags = tcc_pkg::FLAG_ACK;
            last_ack_nxt   = rcv_r;
            seq_nxt        = S_REL;
          end else if (st_r == tcc_pkg::CS_ESTABLISHED) begin
            st_nxt         = tcc_pkg::CS_CLOSE_WAIT;
            push           = 1'b1;
            push_res       = seg_base;
            push_res.flags = tcc_pkg::FLAG_FIN | tcc_pkg::FLAG_ACK;
            last_ack_nxt   = rcv_r;
            enq            = !q_full;
            enq_flags      = tcc_pkg::FLAG_FIN | tcc_pkg::FLAG_ACK;
            snd_nxt        = snd_r + 32'd1;
          end
        end
      end

      // release: reload and report closed
      S_REL: begin
        do_fresh    = 1'b1;
        do_rel      = 1'b1;
        push        = 1'b1;
        push_res.ev = tcc_pkg::EV_CLOSED;
        seq_nxt     = S_FINISH;
      end

      // read done: reopen window
      S_RD: begin
        own_nxt     = rd_w[15:0];
        rd_flag_nxt = (rd_w <= {1'b0, i_len_r}) && (rcv_r == last_ack_r);
        seq_nxt     = S_RD2;
      end

      S_RD2: begin
        if (rd_flag_r) begin
          push           = 1'b1;
          push_res       = seg_base;
          push_res.flags = tcc_pkg::FLAG_ACK;
          last_ack_nxt   = rcv_r;
        end
        seq_nxt = S_FINISH;
      end

      // retransmit or drop the queue head
      S_TICK: begin
        seq_nxt = S_FINISH;
        if (tick_age >= cfg_rto_r) begin
          if (q_rd.cnt > cfg_max_send_r) begin
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
            if ((q_rd.flags & tcc_pkg::FLAG_PSH) != 8'd0) push_pend_nxt = 1'b0;
            push           = 1'b1;
            push_res.ev    = tcc_pkg::EV_WRITTEN;
            push_res.evlen = q_rd.plen;
          end else begin
            push                = 1'b1;
            push_res.send_valid = 1'b1;
            push_res.flags      = q_rd.flags;
            push_res.seq        = q_rd.seq;
            push_res.ack        = q_rd.ack;
            push_res.win        = q_rd.win;
            push_res.plen       = q_rd.plen;
            push_res.doff       = q_rd.doff;
            ram_we              = 1'b1;
            ram_waddr           = head_r;
            ram_wdata           = q_rd;
            ram_wdata.cnt       = (q_rd.cnt == 2'd3) ? 2'd3 : q_rd.cnt + 2'd1;
            ram_wdata.sent      = i_now_r;
          end
        end
      end

      // write split: size the next segment
      S_WCALC: begin
        if (!loop_ok || wl_c == 16'd0) begin
          push           = 1'b1;
          push_res.ev    = tcc_pkg::EV_WR_ACC;
          push_res.evlen = woff_r;
          push_res.last  = 1'b1;
          seq_nxt        = S_FINISH;
        end else begin
          wl_nxt  = wl_c;
          seq_nxt = S_WEMIT;
        end
      end

      // write split: send and queue the segment
      S_WEMIT: begin
        if (fifo_cnt_r < FCW'(FD)) begin
          push           = 1'b1;
          push_res       = seg_base;
          push_res.flags = psh ? (tcc_pkg::FLAG_ACK | tcc_pkg::FLAG_PSH) : tcc_pkg::FLAG_ACK;
          push_res.plen  = wl_r;
          push_res.doff  = woff_r;
          push_res.ev    = is_last ? tcc_pkg::EV_WR_ACC : tcc_pkg::EV_NONE;
          push_res.evlen = is_last ? off_n[15:0] : 16'd0;
          push_res.last  = is_last;
          if (psh) push_pend_nxt = 1'b1;
          last_ack_nxt = rcv_r;
          enq          = 1'b1;
          enq_flags    = push_res.flags;
          enq_plen     = wl_r;
          enq_doff     = woff_r;
          snd_nxt      = snd_r + {16'd0, wl_r};
          woff_nxt     = off_n[15:0];
          pw_nxt       = pw_n;
          wsegs_nxt    = segs_n;
          seq_nxt      = is_last ? S_FINISH : S_WCALC;
        end
      end

      S_FINISH: begin
        set_last = !write_step_r && pushed_r;
        seq_nxt  = S_IDLE;
      end

      default: seq_nxt = S_IDLE;
    endcase

    // queue append at tail
    if (enq) begin
      ram_we          = 1'b1;
      ram_waddr       = tail;
      ram_wdata.seq   = snd_r;
      ram_wdata.ack   = rcv_r;
      ram_wdata.flags = enq_flags;
      ram_wdata.plen  = enq_plen;
      ram_wdata.doff  = enq_doff;
      ram_wdata.cnt   = 2'd1;
      ram_wdata.sent  = i_now_r;
      ram_wdata.win   = own_r;
      count_nxt       = count_r + 1'b1;
    end

    // reload connection from configuration
    if (do_fresh) begin
      st_nxt        = do_rel ? tcc_pkg::CS_RELEASED : tcc_pkg::CS_CLOSED;
      snd_nxt       = cfg_iss_r;
      rcv_nxt       = '0;
      pw_nxt        = '0;
      own_nxt       = cfg_lwin_r;
      peer_mss_nxt  = '0;
      last_ack_nxt  = '0;
      push_pend_nxt = 1'b0;
      fin_time_nxt  = '0;
      head_nxt      = '0;
      count_nxt     = '0;
    end

    if (push) pushed_nxt = 1'b1;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_iss_r      <= tcc_pkg::RST_INIT_SEQ;
      cfg_lwin_r     <= tcc_pkg::RST_LOCAL_WIN;
      cfg_mss_r      <= tcc_pkg::RST_LOCAL_MSS;
      cfg_fin_to_r   <= tcc_pkg::RST_FIN_TO;
      cfg_rto_r      <= tcc_pkg::RST_RTO;
      cfg_max_send_r <= tcc_pkg::RST_MAX_SEND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcc_pkg::CFG_INIT_SEQ:  cfg_iss_r      <= cfg_data;
        tcc_pkg::CFG_LOCAL_WIN: cfg_lwin_r     <= cfg_data[15:0];
        tcc_pkg::CFG_LOCAL_MSS: cfg_mss_r      <= cfg_data[15:0];
        tcc_pkg::CFG_FIN_TO:    cfg_fin_to_r   <= cfg_data;
        tcc_pkg::CFG_RTO:       cfg_rto_r      <= cfg_data;
        tcc_pkg::CFG_MAX_SEND:  cfg_max_send_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // control and connection state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= S_IDLE;
      st_r         <= tcc_pkg::CS_CLOSED;
      snd_r        <= tcc_pkg::RST_INIT_SEQ;
      rcv_r        <= '0;
      last_ack_r   <= '0;
      fin_time_r   <= '0;
      pw_r         <= '0;
      own_r        <= tcc_pkg::RST_LOCAL_WIN;
      peer_mss_r   <= '0;
      push_pend_r  <= 1'b0;
      head_r       <= '0;
      count_r      <= '0;
      write_step_r <= 1'b0;
      pushed_r     <= 1'b0;
      syn_f_r      <= 1'b0;
      fin_f_r      <= 1'b0;
      rd_flag_r    <= 1'b0;
      acc_r        <= '0;
      woff_r       <= '0;
      wl_r         <= '0;
      wsegs_r      <= '0;
    end else begin
      seq_r        <= seq_nxt;
      st_r         <= st_nxt;
      snd_r        <= snd_nxt;
      rcv_r        <= rcv_nxt;
      last_ack_r   <= last_ack_nxt;
      fin_time_r   <= fin_time_nxt;
      pw_r         <= pw_nxt;
      own_r        <= own_nxt;
      peer_mss_r   <= peer_mss_nxt;
      push_pend_r  <= push_pend_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      write_step_r <= write_step_nxt;
      pushed_r     <= pushed_nxt;
      syn_f_r      <= syn_f_nxt;
      fin_f_r      <= fin_f_nxt;
      rd_flag_r    <= rd_flag_nxt;
      acc_r        <= acc_nxt;
      woff_r       <= woff_nxt;
      wl_r         <= wl_nxt;
      wsegs_r      <= wsegs_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      i_action_r      <= in_action;
      i_flags_r       <= in_seg_flags;
      i_seq_r         <= in_seg_seq;
      i_ack_r         <= in_seg_ack;
      i_win_r         <= in_seg_window;
      i_len_r         <= in_length;
      i_mss_present_r <= in_mss_present;
      i_peer_mss_r    <= in_peer_mss;
      i_now_r         <= in_now_ms;
    end
  end

  // result FIFO storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_res;
    end
    if (set_last) begin
      fifo_mem[wr_ptr_r - 1'b1].last <= 1'b1;
    end
  end

  // result FIFO pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      fifo_cnt_r <= fifo_cnt_r + FCW'(push) - FCW'(pop);
    end
  end

  // output ports
  assign out_res            = fifo_mem[rd_ptr_r];
  assign out_send_valid     = out_res.send_valid;
  assign out_tx_flags       = out_res.flags;
  assign out_tx_seq         = out_res.seq;
  assign out_tx_ack         = out_res.ack;
  assign out_tx_window      = out_res.win;
  assign out_tx_payload_len = out_res.plen;
  assign out_tx_data_offset = out_res.doff;
  assign out_event_code     = out_res.ev;
  assign out_event_length   = out_res.evlen;
  assign out_conn_state     = st_r;
  assign out_last           = out_res.last;

  // checks
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= FCW'(FD))
    else $error("result FIFO overflow");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("retransmit queue overflow");

  a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> fifo_cnt_r == '0)
    else $error("request taken with results pending");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_conn_state))
    else $error("connection state moved under a stalled result");

  a_seq_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(seq_r))
    else $error("sequencer state not one-hot");

endmodule

// ----- src/tcc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-cycle write
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- dv/tcc_checker.sv -----
// Checker for the TCP connection controller: watches the request, result and
// config ports, predicts each result from its own connection model and compares.
// Depends on tcc_pkg.
module tcc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_seg_flags,
  input  logic [31:0] in_seg_seq,
  input  logic [31:0] in_seg_ack,
  input  logic [15:0] in_seg_window,
  input  logic [15:0] in_length,
  input  logic        in_mss_present,
  input  logic [15:0] in_peer_mss,
  input  logic [31:0] in_now_ms,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_send_valid,
  input  logic [7:0]  out_tx_flags,
  input  logic [31:0] out_tx_seq,
  input  logic [31:0] out_tx_ack,
  input  logic [15:0] out_tx_window,
  input  logic [15:0] out_tx_payload_len,
  input  logic [15:0] out_tx_data_offset,
  input  logic [2:0]  out_event_code,
  input  logic [15:0] out_event_length,
  input  logic [2:0]  out_conn_state,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);
  import tcc_pkg::*;

  localparam int QD      = QUEUE_DEPTH_DEF;
  localparam int MAX_SEG = MAX_WRITE_SEGMENTS_DEF;
  localparam int MAX_RES = 64;

  typedef struct packed {
    logic        send;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] win;
    logic [15:0] plen;
    logic [15:0] doff;
    logic [2:0]  ev;
    logic [15:0] evlen;
    logic [2:0]  st;
    logic        last;
  } conn_result_t;

  conn_result_t awaited_results[$];
  conn_result_t step_results[$];

  // configuration copy
  logic [31:0] init_seq, fin_to, rto;
  logic [15:0] loc_win, loc_mss;
  logic [1:0]  max_send;

  // connection state
  logic [2:0]  cs;
  logic [31:0] snd_nxt, rcv_nxt, last_ack, fin_start, now;
  logic [15:0] peer_win, own_win, peer_mss;
  logic        push_pend;
  int          q_head, q_count;

  // retransmit queue
  logic [31:0] q_seq [QD];
  logic [31:0] q_ack [QD];
  logic [7:0]  q_flags [QD];
  logic [15:0] q_plen [QD];
  logic [15:0] q_doff [QD];
  logic [1:0]  q_cnt [QD];
  logic [31:0] q_sent [QD];
  logic [15:0] q_win [QD];

  assign pending = awaited_results.size();

  function automatic logic [31:0] seq_after(logic [31:0] sq, logic [7:0] fl, logic [15:0] ln);
    if (ln != 0) return sq + 32'(ln);
    if ((fl & (FLAG_SYN | FLAG_FIN)) != 0) return sq + 32'd1;
    return sq;
  endfunction

  function automatic void put(logic sv, logic [7:0] fl, logic [31:0] sq, logic [31:0] ak,
                              logic [15:0] wn, logic [15:0] pl, logic [15:0] off,
                              logic [2:0] ev, logic [15:0] el);
    conn_result_t r;
    if (step_results.size() >= MAX_RES) return;
    r = '{sv, fl, sq, ak, wn, pl, off, ev, el, 3'd0, 1'b0};
    step_results.push_back(r);
  endfunction

  function automatic void note_event(logic [2:0] ev, logic [15:0] el);
    put(1'b0, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, ev, el);
  endfunction

  function automatic void transmit(logic [7:0] fl, logic [15:0] pl, logic [15:0] off,
                                   bit queued);
    int i;
    put(1'b1, fl, snd_nxt, rcv_nxt, own_win, pl, off, EV_NONE, 16'd0);
    last_ack = rcv_nxt;
    if (queued && q_count < QD) begin
      i = (q_head + q_count) % QD;
      q_seq[i] = snd_nxt; q_ack[i] = rcv_nxt; q_flags[i] = fl; q_plen[i] = pl;
      q_doff[i] = off; q_cnt[i] = 2'd1; q_sent[i] = now; q_win[i] = own_win;
      q_count++;
    end
    snd_nxt = seq_after(snd_nxt, fl, pl);
  endfunction

  function automatic void reload();
    cs = CS_CLOSED; snd_nxt = init_seq; rcv_nxt = 0; peer_win = 0; own_win = loc_win;
    peer_mss = 0; last_ack = 0; push_pend = 0; fin_start = 0; q_head = 0; q_count = 0;
  endfunction

  function automatic void drop_conn();
    reload();
    cs = CS_RELEASED;
    note_event(EV_CLOSED, 16'd0);
  endfunction

  // Retire acknowledged descriptors; returns 1 when the connection was released
  function automatic bit retire_acked(logic [31:0] ak);
    bit syn = 0, fin = 0;
    int unsigned written = 0;
    logic [31:0] d;
    while (q_count > 0) begin
      d = q_seq[q_head] - ak;
      if (!d[31]) break;
      if ((q_flags[q_head] & FLAG_SYN) != 0) begin
        cs = CS_ESTABLISHED;
        syn = 1;
      end
      if (q_plen[q_head] != 0) begin
        if ((q_flags[q_head] & FLAG_PSH) != 0) push_pend = 0;
        written += q_plen[q_head];
      end
      if ((q_flags[q_head] & FLAG_FIN) != 0) fin = 1;
      q_head = (q_head + 1) % QD;
      q_count--;
    end
    if (syn) note_event(EV_CONNECT, 16'd0);
    if (written > 0) note_event(EV_WRITTEN, written > 65535 ? 16'hFFFF : written[15:0]);
    if (fin) begin
      if (cs == CS_FIN_WAIT_1) begin
        cs = CS_FIN_WAIT_2;
        fin_start = now;
      end else if (cs == CS_CLOSE_WAIT) begin
        drop_conn();
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void seg_arrival(logic [7:0] fl, logic [31:0] sq, logic [31:0] ak,
                                      logic [15:0] wn, logic [15:0] ln);
    if (cs == CS_CLOSED || cs == CS_RELEASED) begin
      if ((fl & FLAG_SYN) == 0) begin
        if ((fl & FLAG_RST) == 0)
          put(1'b1, FLAG_RST | FLAG_ACK, ak, seq_after(sq, fl, ln), loc_win, 16'd0, 16'd0,
              EV_NONE, 16'd0);
        return;
      end
      reload();
    end
    // keepalive probe or out of order: bare ACK
    if (fl == FLAG_ACK && sq == rcv_nxt - 32'd1) begin
      transmit(FLAG_ACK, 16'd0, 16'd0, 0);
      return;
    end
    if (rcv_nxt != 0 && sq != rcv_nxt) begin
      transmit(FLAG_ACK, 16'd0, 16'd0, 0);
      return;
    end
    rcv_nxt = seq_after(sq, fl, ln);
    peer_win = wn;
    if ((fl & FLAG_PSH) != 0 || ln != 0) begin
      own_win = own_win > ln ? own_win - ln : 16'd0;
      note_event(EV_RECEIVED, ln);
      if (ln != 0) transmit(FLAG_ACK, 16'd0, 16'd0, 0);
    end
    if ((fl & FLAG_ACK) != 0 && retire_acked(ak)) return;
    if ((fl & FLAG_RST) != 0) begin
      drop_conn();
      return;
    end
    if ((fl & FLAG_SYN) != 0) begin
      cs = CS_WAIT_EST;
      note_event(EV_NEW_CONN, 16'd0);
    end
    if ((fl & FLAG_FIN) != 0) begin
      if (cs == CS_FIN_WAIT_2) begin
        transmit(FLAG_ACK, 16'd0, 16'd0, 0);
        drop_conn();
      end else if (cs == CS_ESTABLISHED) begin
        cs = CS_CLOSE_WAIT;
        transmit(FLAG_FIN | FLAG_ACK, 16'd0, 16'd0, 1);
      end
    end
  endfunction

  // Cut a write into MSS sized segments
  function automatic void app_write(logic [15:0] ln);
    int unsigned offset = 0, segs = 0, wl;
    int first;
    logic [7:0] fl;
    first = step_results.size();
    if (cs != CS_ESTABLISHED || push_pend) begin
      note_event(EV_WR_ACC, 16'd0);
      return;
    end
    while (offset < ln && peer_win > 0 && segs < MAX_SEG && q_count < QD) begin
      wl = peer_mss;
      if (offset + wl > ln) wl = ln - offset;
      if (wl > peer_win) wl = peer_win;
      if (wl == 0) break;
      fl = FLAG_ACK;
      if (offset + wl >= ln || wl >= peer_win) begin
        fl = fl | FLAG_PSH;
        push_pend = 1;
      end
      transmit(fl, wl[15:0], offset[15:0], 1);
      offset += wl;
      peer_win = peer_win - wl[15:0];
      segs++;
    end
    if (step_results.size() > first) begin
      step_results[step_results.size() - 1].ev    = EV_WR_ACC;
      step_results[step_results.size() - 1].evlen = offset[15:0];
    end else begin
      note_event(EV_WR_ACC, offset[15:0]);
    end
  endfunction

  function automatic void timer_tick();
    logic [31:0] age;
    int i;
    age = now - fin_start;
    if ((cs == CS_FIN_WAIT_1 || cs == CS_FIN_WAIT_2) && age >= fin_to) begin
      drop_conn();
      return;
    end
    if (q_count == 0) return;
    i = q_head;
    age = now - q_sent[i];
    if (age < rto) return;
    if (q_cnt[i] > max_send) begin
      q_head = (q_head + 1) % QD;
      q_count--;
      if ((q_flags[i] & FLAG_PSH) != 0) push_pend = 0;
      note_event(EV_WRITTEN, q_plen[i]);
    end else begin
      put(1'b1, q_flags[i], q_seq[i], q_ack[i], q_win[i], q_plen[i], q_doff[i],
          EV_NONE, 16'd0);
      if (q_cnt[i] != 2'd3) q_cnt[i] = q_cnt[i] + 2'd1;
      q_sent[i] = now;
    end
  endfunction

  function automatic void predict_request();
    logic [31:0] w;
    now = in_now_ms;
    step_results.delete();
    case (in_action)
      ACT_SEGMENT: seg_arrival(in_seg_flags, in_seg_seq, in_seg_ack, in_seg_window, in_length);
      ACT_ACCEPT: begin
        if (cs == CS_WAIT_EST) begin
          cs = CS_ESTABLISHING;
          if (in_mss_present) peer_mss = in_peer_mss;
          transmit(FLAG_SYN | FLAG_ACK, 16'd0, loc_mss, 1);
        end
      end
      ACT_WRITE: app_write(in_length);
      ACT_READ_DONE: begin
        if (cs == CS_ESTABLISHED) begin
          w = 32'(own_win) + 32'(in_length);
          if (w > 32'(loc_win)) w = 32'(loc_win);
          own_win = w[15:0];
          if (w <= 32'(in_length) && rcv_nxt == last_ack) transmit(FLAG_ACK, 16'd0, 16'd0, 0);
        end
      end
      ACT_CLOSE: begin
        if (cs == CS_CLOSED) begin
          drop_conn();
        end else if (cs == CS_WAIT_EST || cs == CS_ESTABLISHING) begin
          transmit(FLAG_RST | FLAG_ACK, 16'd0, 16'd0, 0);
          drop_conn();
        end else if (cs == CS_ESTABLISHED) begin
          cs = CS_FIN_WAIT_1;
          fin_start = now;
          transmit(FLAG_FIN | FLAG_ACK, 16'd0, 16'd0, 1);
        end
      end
      ACT_TICK: timer_tick();
      default: ;
    endcase
    foreach (step_results[k]) begin
      step_results[k].st   = cs;
      step_results[k].last = (k == step_results.size() - 1);
      awaited_results.push_back(step_results[k]);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      fail_count++;
    end
  endfunction

  function automatic void compare_result();
    conn_result_t e;
    if (awaited_results.size() == 0) begin
      $error("result with no request outstanding: flags 0x%0h event %0d",
             out_tx_flags, out_event_code);
      fail_count++;
      return;
    end
    e = awaited_results.pop_front();
    check_field("send_valid", 32'(e.send), 32'(out_send_valid));
    check_field("tx_flags", 32'(e.flags), 32'(out_tx_flags));
    check_field("tx_seq", e.seq, out_tx_seq);
    check_field("tx_ack", e.ack, out_tx_ack);
    check_field("tx_window", 32'(e.win), 32'(out_tx_window));
    check_field("tx_payload_len", 32'(e.plen), 32'(out_tx_payload_len));
    check_field("tx_data_offset", 32'(e.doff), 32'(out_tx_data_offset));
    check_field("event_code", 32'(e.ev), 32'(out_event_code));
    check_field("event_length", 32'(e.evlen), 32'(out_event_length));
    check_field("conn_state", 32'(e.st), 32'(out_conn_state));
    check_field("last", 32'(e.last), 32'(out_last));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      init_seq = RST_INIT_SEQ; loc_win = RST_LOCAL_WIN; loc_mss = RST_LOCAL_MSS;
      fin_to = RST_FIN_TO; rto = RST_RTO; max_send = RST_MAX_SEND;
      reload();
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) compare_result();
      if (in_valid && !in_stall) predict_request();
      if (cfg_we) begin
        case (cfg_index)
          CFG_INIT_SEQ:  init_seq = cfg_data;
          CFG_LOCAL_WIN: loc_win = cfg_data[15:0];
          CFG_LOCAL_MSS: loc_mss = cfg_data[15:0];
          CFG_FIN_TO:    fin_to = cfg_data;
          CFG_RTO:       rto = cfg_data;
          CFG_MAX_SEND:  max_send = cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- dv/tcp_connection_controller_top_test.sv -----
// Testbench top for the TCP connection controller: clock, reset, config phases,
// directed and random requests with random idling, and the final verdict.
// Depends on tcc_pkg, tcp_connection_controller_top and tcc_checker.
module tcp_connection_controller_top_test;
  import tcc_pkg::*;

  localparam int REQ_TARGET  = 430;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_stall;
  logic [2:0]  in_action;
  logic [7:0]  in_seg_flags;
  logic [31:0] in_seg_seq, in_seg_ack;
  logic [15:0] in_seg_window, in_length;
  logic        in_mss_present;
  logic [15:0] in_peer_mss;
  logic [31:0] in_now_ms;
  logic        out_valid, out_stall;
  logic        out_send_valid;
  logic [7:0]  out_tx_flags;
  logic [31:0] out_tx_seq, out_tx_ack;
  logic [15:0] out_tx_window, out_tx_payload_len, out_tx_data_offset;
  logic [2:0]  out_event_code;
  logic [15:0] out_event_length;
  logic [2:0]  out_conn_state;
  logic        out_last;
  int          fail_count, pending;

  logic [31:0] iss;
  logic [31:0] clock_ms;
  bit          calm;
  int          n_req;
  int          cycles;

  tcp_connection_controller_top dut (.*);
  tcc_checker chk (.*);

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 12);
  end

  // one request, held until taken
  task automatic send_req(input logic [2:0] act, input logic [7:0] fl, input logic [31:0] sq,
                          input logic [31:0] ak, input logic [15:0] wn, input logic [15:0] ln,
                          input logic mp, input logic [15:0] mss);
    clock_ms = clock_ms + $urandom_range(0, 40);
    if (!calm) begin
      while ($urandom_range(99) < 12) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_action <= act; in_seg_flags <= fl; in_seg_seq <= sq; in_seg_ack <= ak;
    in_seg_window <= wn; in_length <= ln; in_mss_present <= mp; in_peer_mss <= mss;
    in_now_ms <= clock_ms;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_req++;
  endtask

  task automatic seg(input logic [7:0] fl, input logic [31:0] sq, input logic [31:0] ak,
                     input logic [15:0] wn, input logic [15:0] ln);
    send_req(ACT_SEGMENT, fl, sq, ak, wn, ln, 1'($urandom), 16'($urandom));
  endtask

  task automatic app(input logic [2:0] act, input logic [15:0] ln);
    send_req(act, 8'($urandom), $urandom, $urandom, 16'($urandom), ln, 1'($urandom),
             16'($urandom));
  endtask

  // wait until every result is in and the sequencer has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_we    <= 1'b1;
    if (idx == CFG_INIT_SEQ) iss = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int phase);
    case (phase)
      0: begin
        write_cfg(CFG_INIT_SEQ, 32'hFFFF_FFF0); write_cfg(CFG_LOCAL_WIN, 32'd65535);
        write_cfg(CFG_LOCAL_MSS, 32'd1460);     write_cfg(CFG_FIN_TO, 32'd20000);
        write_cfg(CFG_RTO, 32'd2000);           write_cfg(CFG_MAX_SEND, 32'd2);
      end
      1: begin
        write_cfg(CFG_INIT_SEQ, $urandom); write_cfg(CFG_LOCAL_WIN, 32'd2000);
        write_cfg(CFG_LOCAL_MSS, 32'd0);   write_cfg(CFG_FIN_TO, 32'd0);
        write_cfg(CFG_RTO, 32'd0);         write_cfg(CFG_MAX_SEND, 32'd0);
      end
      2: begin
        write_cfg(CFG_INIT_SEQ, 32'hFFFF_FFFF); write_cfg(CFG_LOCAL_WIN, 32'd65535);
        write_cfg(CFG_LOCAL_MSS, 32'd65535);    write_cfg(CFG_FIN_TO, 32'hFFFF_FFFF);
        write_cfg(CFG_RTO, 32'hFFFF_FFFF);      write_cfg(CFG_MAX_SEND, 32'd3);
      end
      3: begin
        write_cfg(CFG_INIT_SEQ, 32'd0);  write_cfg(CFG_LOCAL_WIN, 32'd0);
        write_cfg(CFG_LOCAL_MSS, $urandom); write_cfg(CFG_FIN_TO, 32'd5000);
        write_cfg(CFG_RTO, 32'd500);     write_cfg(CFG_MAX_SEND, 32'd1);
      end
      default: begin
        write_cfg(CFG_INIT_SEQ, $urandom);
        write_cfg(CFG_LOCAL_WIN, $urandom_range(0, 65535));
        write_cfg(CFG_LOCAL_MSS, $urandom_range(0, 65535));
        write_cfg(CFG_FIN_TO, $urandom_range(0, 40000));
        write_cfg(CFG_RTO, $urandom_range(0, 4000));
        write_cfg(CFG_MAX_SEND, $urandom_range(0, 3));
      end
    endcase
  endtask

  // One passive open, random traffic, then one of several teardowns or none
  task automatic connection(input bit no_mss);
    logic [31:0] peer;
    logic [15:0] ln, mss;
    logic [7:0]  psh;
    int unsigned sent;
    sent = 0;
    peer = $urandom;
    seg(FLAG_SYN, peer, $urandom, 16'($urandom), 16'd0);
    peer = peer + 32'd1;
    case ($urandom_range(0, 9))
      0: mss = 16'd0;
      1: mss = 16'hFFFF;
      default: mss = 16'($urandom_range(1, 1500));
    endcase
    send_req(ACT_ACCEPT, 8'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom),
             !no_mss && ($urandom_range(0, 9) != 0), mss);
    seg(FLAG_ACK, peer, iss + 32'd1, 16'($urandom_range(0, 65535)), 16'd0);
    repeat ($urandom_range(4, 14)) begin
      case ($urandom_range(0, 6))
        0: begin
          ln = 16'($urandom_range(0, 3000));
          psh = $urandom_range(0, 1) ? FLAG_PSH : 8'd0;
          seg(FLAG_ACK | psh, peer, iss + 32'd1 + $urandom_range(0, sent),
              16'($urandom), ln);
          peer = peer + 32'(ln);
        end
        1: begin
          ln = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 6000));
          app(ACT_WRITE, ln);
          sent += ln;
        end
        2: seg(FLAG_ACK, peer, iss + 32'd1 + $urandom_range(0, sent), 16'($urandom), 16'd0);
        3: app(ACT_READ_DONE, 16'($urandom_range(0, 4000)));
        4: begin
          clock_ms = clock_ms + $urandom_range(0, 2500);
          app(ACT_TICK, 16'd0);
        end
        5: seg(FLAG_ACK, peer - 32'd1, iss + 32'd1, 16'($urandom), 16'd0);
        default: seg(8'($urandom) & ~FLAG_SYN, peer + $urandom_range(1, 9), $urandom,
                     16'($urandom), 16'($urandom_range(0, 100)));
      endcase
    end
    case ($urandom_range(0, 4))
      0: begin
        app(ACT_CLOSE, 16'd0);
        seg(FLAG_ACK, peer, iss + 32'd2 + sent, 16'($urandom), 16'd0);
        seg(FLAG_FIN | FLAG_ACK, peer, iss + 32'd2 + sent, 16'($urandom), 16'd0);
      end
      1: begin
        seg(FLAG_FIN | FLAG_ACK, peer, iss + 32'd1 + sent, 16'($urandom), 16'd0);
        peer = peer + 32'd1;
        seg(FLAG_ACK, peer, iss + 32'd2 + sent, 16'($urandom), 16'd0);
      end
      2: seg(FLAG_RST, peer, $urandom, 16'($urandom), 16'd0);
      3: begin
        app(ACT_CLOSE, 16'd0);
        repeat ($urandom_range(1, 4)) begin
          clock_ms = clock_ms + $urandom_range(0, 30000);
          app(ACT_TICK, 16'd0);
        end
      end
      default: ;
    endcase
  endtask

  // stimulus
  initial begin
    int phase, start;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_action = '0; in_seg_flags = '0; in_seg_seq = '0; in_seg_ack = '0;
    in_seg_window = '0; in_length = '0; in_mss_present = 1'b0; in_peer_mss = '0;
    in_now_ms = '0; out_stall = 1'b0;
    iss = RST_INIT_SEQ; clock_ms = 32'hFFFF_0000; calm = 0; n_req = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: no connection, ignored codes, refused requests
    seg(8'hFF & ~FLAG_SYN & ~FLAG_RST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    seg(FLAG_RST, 32'd0, 32'd0, 16'd0, 16'd0);
    seg(FLAG_FIN, 32'h1234_5678, 32'd0, 16'd0, 16'd0);
    app(ACT_WRITE, 16'd100);
    app(ACT_READ_DONE, 16'hFFFF);
    app(ACT_ACCEPT, 16'd0);
    app(ACT_TICK, 16'd0);
    app(3'd6, 16'd0);
    app(3'd7, 16'hFFFF);
    app(ACT_CLOSE, 16'd0);
    app(ACT_CLOSE, 16'd0);
    connection(1);
    connection(0);

    phase = 0;
    while (n_req < REQ_TARGET) begin
      settle();
      configure(phase);
      calm = (phase == 2);
      start = n_req;
      while (n_req < start + 90 && n_req < REQ_TARGET) begin
        if ($urandom_range(99) < 15)
          send_req(3'($urandom_range(0, 7)), 8'($urandom), $urandom, $urandom,
                   16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
        else
          connection($urandom_range(0, 19) == 0);
      end
      phase++;
    end
    calm = 0;

    settle();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
